[rtl/dzv_pkg.sv]
// Shared constants and types for the delta zigzag varint encoder.
package dzv_pkg;

  localparam int DATA_W    = 64;
  localparam int GROUP_W   = 7;
  localparam int MAX_BYTES = 10;
  localparam int NB_W      = $clog2(MAX_BYTES + 1);

  // Queue between front and back; depth must be a power of two
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] MORE_BIT = 8'h80;

  // One classified item: zigzag code and the number of varint bytes it needs
  typedef struct packed {
    logic [DATA_W-1:0] code;
    logic [NB_W-1:0]   nbytes;
  } dzv_item_t;

endpackage

[rtl/dzv_front.sv]
// Front end: takes samples, forms the zigzag delta and counts its varint bytes.
module dzv_front
  import dzv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     first,
  output logic                     push,
  output dzv_item_t                push_item,
  input  logic                     q_full
);

  logic              fr_valid;
  logic [DATA_W-1:0] fr_code;
  logic [DATA_W-1:0] prev_value;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] delta;
  logic [NB_W-1:0]   nbytes;
  logic              take;
  logic              accept;

  // Advance the stage whenever it is empty or its item moves into the queue
  assign push     = fr_valid && !q_full;
  assign take     = !fr_valid || push;
  assign in_stall = !take;
  assign accept   = in_valid && take;

  // Delta against the previous sample, zero at the start of a sequence
  assign base  = first ? '0 : prev_value;
  assign delta = $unsigned(value) - base;

  // Hold the control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid   <= 1'b0;
      prev_value <= '0;
    end else begin
      if (take) begin
        fr_valid <= in_valid;
      end
      if (accept) begin
        prev_value <= $unsigned(value);
      end
    end
  end

  // Zigzag map into the stage register
  always_ff @(posedge clk) begin
    if (accept) begin
      fr_code <= {delta[DATA_W-2:0], 1'b0} ^ {DATA_W{delta[DATA_W-1]}};
    end
  end

  // Count bytes: one more than the index of the highest non-zero seven-bit group
  always_comb begin
    nbytes = NB_W'(1);
    for (int i = 1; i < MAX_BYTES; i++) begin
      if ((fr_code >> (GROUP_W * i)) != '0) begin
        nbytes = NB_W'(i + 1);
      end
    end
  end

  assign push_item.code   = fr_code;
  assign push_item.nbytes = nbytes;

endmodule

[rtl/dzv_queue.sv]
// Short queue of classified items between the front and the back end.
module dzv_queue
  import dzv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  dzv_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output dzv_item_t head
);

  dzv_item_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue occupancy out of range");

endmodule

[rtl/dzv_back.sv]
// Back end: splits each zigzag code into varint bytes, one per cycle unless stalled.
module dzv_back
  import dzv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  dzv_item_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] code_byte,
  output logic      last
);

  logic              busy;
  logic [DATA_W-1:0] shreg;
  logic [NB_W-1:0]   rem;
  logic [DATA_W-1:0] src;
  logic [NB_W-1:0]   cnt;
  logic              have;
  logic              load;
  logic              is_last;

  // Pick the item in progress, else the queue head
  assign src     = busy ? shreg : head.code;
  assign cnt     = busy ? rem : head.nbytes;
  assign have    = busy || head_valid;
  assign load    = !out_valid || !out_stall;
  assign pop     = load && !busy && head_valid;
  assign is_last = cnt == NB_W'(1);

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else if (load) begin
      out_valid <= have;
      busy      <= have && !is_last;
    end
  end

  // Emit the low group and shift the rest down
  always_ff @(posedge clk) begin
    if (load && have) begin
      code_byte <= is_last ? src[7:0] : (MORE_BIT | {1'b0, src[GROUP_W-1:0]});
      last      <= is_last;
      shreg     <= src >> GROUP_W;
      rem       <= cnt - NB_W'(1);
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem != '0 && rem <= NB_W'(MAX_BYTES - 1)))
    else $error("remaining byte count out of range");

  a_more_bit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> code_byte[7])
    else $error("continuation byte without more bit");

  a_busy_after_more: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> busy)
    else $error("continuation byte with no item in progress");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pop)
    else $error("queue read while an item is in progress");

endmodule

[rtl/delta_zigzag_varint_encoder_core.sv]
// Top level: delta, zigzag and base-128 varint encoder for signed 64-bit samples.
// The first byte of a sample passes the front stage register, the queue and the back
// end's output byte register. The back end gives one byte per cycle while out_stall
// is low; a sample gives 1 to 10 bytes, one per seven-bit group of its zigzag delta.
// Samples flow back to back; a two-entry queue decouples input from output.
// Reset clears the previous sample to zero, empties the queue and drops all valids.
module delta_zigzag_varint_encoder_core
  import dzv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     first,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               code_byte,
  output logic                     last
);

  logic      push;
  dzv_item_t push_item;
  logic      q_full;
  logic      pop;
  logic      head_valid;
  dzv_item_t head;

  dzv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .first     (first),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  dzv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dzv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_byte  (code_byte),
    .last       (last)
  );

endmodule
